// File: design/mmcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcf_pkg
// types and constants shared by the multicycle mips control unit
// ----------------------------------------------------------------------------
package mmcf_pkg;

  // instruction phase
  typedef enum logic [1:0] {
    PH_FETCH  = 2'd0,
    PH_DECODE = 2'd1,
    PH_EXEC   = 2'd2,
    PH_MEM    = 2'd3
  } phase_t;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  // r-type function codes
  localparam logic [5:0] FN_HALT  = 6'h0c;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_SUB   = 6'h22;

  // load enable bit positions
  localparam int LE_PC    = 0;
  localparam int LE_IR    = 1;
  localparam int LE_REG   = 2;
  localparam int LE_MAR   = 3;
  localparam int LE_ALU   = 4;
  localparam int LE_LOAD  = 5;
  localparam int LE_STORE = 6;
  localparam int LE_W     = 7;

  // alu b operand select codes
  localparam logic [1:0] BSEL_REG    = 2'd0;
  localparam logic [1:0] BSEL_FOUR   = 2'd1;
  localparam logic [1:0] BSEL_IMM    = 2'd2;
  localparam logic [1:0] BSEL_IMM_X4 = 2'd3;

  // alu function codes
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  // one beat of control outputs
  typedef struct packed {
    logic              halted;
    logic              mem_read;
    logic              mem_write;
    logic [LE_W-1:0]   load_enables;
    logic              write_reg_select;
    logic              pc_select;
    logic              addr_select;
    logic              a_select;
    logic [1:0]        b_select;
    logic              reg_write_select;
    logic              alu_func;
    phase_t            phase;
  } ctrl_t;

endpackage
`default_nettype wire

// File: design/mmcf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcf_in_if / mmcf_out_if
// valid/ready channels for instruction fields and control beats
// ----------------------------------------------------------------------------
interface mmcf_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] opcode;
  logic [5:0] func_field;
  logic       zero;

  modport source (output valid, output opcode, output func_field, output zero,
                  input ready);
  modport sink (input valid, input opcode, input func_field, input zero,
                output ready);
endinterface

interface mmcf_out_if;
  logic       valid;
  logic       ready;
  logic       halted;
  logic       mem_read;
  logic       mem_write;
  logic [6:0] load_enables;
  logic       write_reg_select;
  logic       pc_select;
  logic       addr_select;
  logic       a_select;
  logic [1:0] b_select;
  logic       reg_write_select;
  logic       alu_func;
  logic [1:0] phase;

  modport source (output valid, output halted, output mem_read, output mem_write,
                  output load_enables, output write_reg_select, output pc_select,
                  output addr_select, output a_select, output b_select,
                  output reg_write_select, output alu_func, output phase,
                  input ready);
  modport sink (input valid, input halted, input mem_read, input mem_write,
                input load_enables, input write_reg_select, input pc_select,
                input addr_select, input a_select, input b_select,
                input reg_write_select, input alu_func, input phase,
                output ready);
endinterface
`default_nettype wire

// File: design/mmcf_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcf_decode
// phase and instruction decode: control beat, next phase, halt request
// ----------------------------------------------------------------------------
module mmcf_decode (
  input  var mmcf_pkg::phase_t phase,
  input  var logic             halt_flag,
  input  var logic [5:0]       opcode,
  input  var logic [5:0]       func_field,
  input  var logic             zero,
  output mmcf_pkg::ctrl_t      ctrl,
  output mmcf_pkg::phase_t     phase_next,
  output logic                 halt_set
);

  logic is_add;
  logic is_sub;
  logic is_branch;
  logic take;

  assign is_add    = (opcode == mmcf_pkg::OP_RTYPE) && (func_field == mmcf_pkg::FN_ADD);
  assign is_sub    = (opcode == mmcf_pkg::OP_RTYPE) && (func_field == mmcf_pkg::FN_SUB);
  assign is_branch = (opcode == mmcf_pkg::OP_BEQ) || (opcode == mmcf_pkg::OP_BNE);
  assign take      = (opcode == mmcf_pkg::OP_BEQ) ? zero : !zero;

  always_comb begin
    ctrl       = '0;
    ctrl.phase = phase;
    phase_next = phase;
    halt_set   = 1'b0;
    if (halt_flag) begin
      halt_set = 1'b1;
    end else begin
      unique case (phase)
        mmcf_pkg::PH_FETCH: begin
          phase_next = mmcf_pkg::PH_DECODE;
          ctrl.mem_read = 1'b1;
          ctrl.load_enables[mmcf_pkg::LE_PC] = 1'b1;
          ctrl.load_enables[mmcf_pkg::LE_IR] = 1'b1;
          ctrl.b_select = mmcf_pkg::BSEL_FOUR;
        end
        mmcf_pkg::PH_DECODE: begin
          priority if (opcode == mmcf_pkg::OP_RTYPE && func_field == mmcf_pkg::FN_HALT) begin
            halt_set = 1'b1;
          end else if (opcode == mmcf_pkg::OP_J) begin
            phase_next = mmcf_pkg::PH_FETCH;
            ctrl.load_enables[mmcf_pkg::LE_PC] = 1'b1;
            ctrl.pc_select = 1'b1;
          end else if (opcode == mmcf_pkg::OP_ADDI) begin
            phase_next = mmcf_pkg::PH_EXEC;
            ctrl.load_enables[mmcf_pkg::LE_ALU] = 1'b1;
            ctrl.a_select = 1'b1;
            ctrl.b_select = mmcf_pkg::BSEL_IMM;
          end else if (is_add || is_sub) begin
            phase_next = mmcf_pkg::PH_EXEC;
            ctrl.load_enables[mmcf_pkg::LE_ALU] = 1'b1;
            ctrl.a_select = 1'b1;
            ctrl.b_select = mmcf_pkg::BSEL_REG;
            ctrl.alu_func = is_sub ? mmcf_pkg::ALU_SUB : mmcf_pkg::ALU_ADD;
          end else if (opcode == mmcf_pkg::OP_SW) begin
            phase_next = mmcf_pkg::PH_EXEC;
            ctrl.load_enables[mmcf_pkg::LE_MAR]   = 1'b1;
            ctrl.load_enables[mmcf_pkg::LE_STORE] = 1'b1;
            ctrl.a_select = 1'b1;
            ctrl.b_select = mmcf_pkg::BSEL_IMM;
          end else if (opcode == mmcf_pkg::OP_LW) begin
            phase_next = mmcf_pkg::PH_EXEC;
            ctrl.load_enables[mmcf_pkg::LE_MAR] = 1'b1;
            ctrl.a_select = 1'b1;
            ctrl.b_select = mmcf_pkg::BSEL_IMM;
          end else if (is_branch) begin
            phase_next = mmcf_pkg::PH_EXEC;
            ctrl.a_select = 1'b1;
            ctrl.b_select = mmcf_pkg::BSEL_REG;
            ctrl.alu_func = mmcf_pkg::ALU_SUB;
          end else begin
            halt_set = 1'b1;
          end
        end
        mmcf_pkg::PH_EXEC: begin
          priority if (opcode == mmcf_pkg::OP_ADDI) begin
            phase_next = mmcf_pkg::PH_FETCH;
            ctrl.load_enables[mmcf_pkg::LE_REG] = 1'b1;
            ctrl.write_reg_select = 1'b1;
          end else if (is_add || is_sub) begin
            phase_next = mmcf_pkg::PH_FETCH;
            ctrl.load_enables[mmcf_pkg::LE_REG] = 1'b1;
          end else if (opcode == mmcf_pkg::OP_SW) begin
            phase_next = mmcf_pkg::PH_FETCH;
            ctrl.mem_write = 1'b1;
            ctrl.addr_select = 1'b1;
          end else if (opcode == mmcf_pkg::OP_LW) begin
            phase_next = mmcf_pkg::PH_MEM;
            ctrl.mem_read = 1'b1;
            ctrl.load_enables[mmcf_pkg::LE_LOAD] = 1'b1;
            ctrl.addr_select = 1'b1;
          end else if (is_branch) begin
            phase_next = mmcf_pkg::PH_FETCH;
            if (take) begin
              ctrl.load_enables[mmcf_pkg::LE_PC] = 1'b1;
              ctrl.b_select = mmcf_pkg::BSEL_IMM_X4;
            end
          end else begin
            halt_set = 1'b1;
          end
        end
        mmcf_pkg::PH_MEM: begin
          if (opcode == mmcf_pkg::OP_LW) begin
            phase_next = mmcf_pkg::PH_FETCH;
            ctrl.load_enables[mmcf_pkg::LE_REG] = 1'b1;
            ctrl.write_reg_select = 1'b1;
            ctrl.reg_write_select = 1'b1;
          end else begin
            halt_set = 1'b1;
          end
        end
        default: begin
          halt_set = 1'b1;
        end
      endcase
    end
    ctrl.halted = halt_set;
  end

endmodule
`default_nettype wire

// File: design/multicycle_mips_control_fsm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multicycle_mips_control_fsm_core
// control unit for a multicycle mips subset, one control beat per instruction beat
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  fetch    in   opcode, func_field, zero                         valid/ready
//  ctrl     out  halted, strobes, load_enables, selects, alu_func, valid/ready
//                phase
//
// one beat in gives one beat out, through the input register, decode and the
// result register; a new beat is taken every cycle while ctrl takes its beats
// phase and sticky halt flag update when a beat moves from the input
// register into the result register
// stalls on ctrl back up through both registers; fetch.ready drops only when
// both stages are full and the result is not taken
// rst is synchronous: phase to fetch, halt flag and both valid bits cleared
// ----------------------------------------------------------------------------
module multicycle_mips_control_fsm_core (
  input  var logic   clk,
  input  var logic   rst,
  mmcf_in_if.sink    fetch,
  mmcf_out_if.source ctrl
);

  // input register
  logic       in_valid;
  logic [5:0] in_opcode;
  logic [5:0] in_func;
  logic       in_zero;

  // result register
  logic            res_valid;
  mmcf_pkg::ctrl_t res;

  // architectural state
  mmcf_pkg::phase_t cur_phase;
  mmcf_pkg::phase_t cur_phase_next;
  logic             halt_flag;
  logic             halt_flag_next;

  // decode outputs
  mmcf_pkg::ctrl_t  dec_ctrl;
  mmcf_pkg::phase_t dec_phase_next;
  logic             dec_halt;

  logic res_load;
  logic in_load;

  // result stage loads when it is empty or its beat is being taken
  assign res_load    = in_valid && (!res_valid || ctrl.ready);
  assign fetch.ready = !in_valid || res_load;
  assign in_load     = fetch.valid && fetch.ready;

  mmcf_decode u_decode (
    .phase      (cur_phase),
    .halt_flag  (halt_flag),
    .opcode     (in_opcode),
    .func_field (in_func),
    .zero       (in_zero),
    .ctrl       (dec_ctrl),
    .phase_next (dec_phase_next),
    .halt_set   (dec_halt)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= 1'b1;
    end else if (res_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_opcode <= fetch.opcode;
      in_func   <= fetch.func_field;
      in_zero   <= fetch.zero;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_phase <= mmcf_pkg::PH_FETCH;
      halt_flag <= 1'b0;
    end else begin
      cur_phase <= cur_phase_next;
      halt_flag <= halt_flag_next;
    end
  end

  // next state: phase holds once halt is raised
  always_comb begin
    cur_phase_next = cur_phase;
    halt_flag_next = halt_flag;
    if (res_load) begin
      if (dec_halt) begin
        halt_flag_next = 1'b1;
      end else begin
        cur_phase_next = dec_phase_next;
      end
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (ctrl.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= dec_ctrl;
    end
  end

  assign ctrl.valid            = res_valid;
  assign ctrl.halted           = res.halted;
  assign ctrl.mem_read         = res.mem_read;
  assign ctrl.mem_write        = res.mem_write;
  assign ctrl.load_enables     = res.load_enables;
  assign ctrl.write_reg_select = res.write_reg_select;
  assign ctrl.pc_select        = res.pc_select;
  assign ctrl.addr_select      = res.addr_select;
  assign ctrl.a_select         = res.a_select;
  assign ctrl.b_select         = res.b_select;
  assign ctrl.reg_write_select = res.reg_write_select;
  assign ctrl.alu_func         = res.alu_func;
  assign ctrl.phase            = res.phase;

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag cleared without reset");

  // a halted beat carries only default controls
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.halted) |->
      (!res.mem_read && !res.mem_write && res.load_enables == '0))
    else $error("halted beat drives controls");

  // memory is never read and written in the same beat
  a_mem_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.mem_read && res.mem_write))
    else $error("memory read and write together");

  // a fetch beat that is issued always moves the phase on to decode
  a_fetch_adv: assert property (@(posedge clk) disable iff (rst)
    (res_load && !halt_flag && cur_phase == mmcf_pkg::PH_FETCH) |=>
      (cur_phase == mmcf_pkg::PH_DECODE))
    else $error("fetch did not advance to decode");

  // phase only moves when a beat is issued
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !res_load |=> $stable(cur_phase))
    else $error("phase moved without a beat");

endmodule
`default_nettype wire

// File: tb/mmcf_ctrl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcf_ctrl_checker
// watches the fetch and ctrl channels of the multicycle mips control unit,
// predicts one control beat per accepted fetch beat and compares in order
// ----------------------------------------------------------------------------
module mmcf_ctrl_checker
  import mmcf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mmcf_in_if   fetch_mon,
  mmcf_out_if  ctrl_mon,
  output int   fail_count,
  output int   ctrl_due_count
);

  // predicted control beats, oldest first
  ctrl_t  ctrl_due_q[$];

  // private copy of the control state
  phase_t model_phase;
  logic   model_halt;
  int     ctrl_beat_no;

  initial begin
    fail_count     = 0;
    ctrl_due_count = 0;
    ctrl_beat_no   = 0;
    model_phase    = PH_FETCH;
    model_halt     = 1'b0;
  end

  // control outputs for one fetch beat and the phase that follows it
  function automatic void ctrl_for_beat(input phase_t ph, input logic stuck,
                                        input logic [5:0] op, input logic [5:0] fn,
                                        input logic z, output ctrl_t c,
                                        output phase_t nxt);
    logic arith;
    logic taken;
    arith = (op == OP_RTYPE) && (fn == FN_ADD || fn == FN_SUB);
    taken = (op == OP_BEQ) ? z : !z;
    c       = '0;
    c.phase = ph;
    nxt     = ph;
    if (stuck) begin
      c.halted = 1'b1;
    end else begin
      case (ph)
        PH_FETCH: begin
          nxt = PH_DECODE;
          c.mem_read = 1'b1;
          c.load_enables[LE_PC] = 1'b1;
          c.load_enables[LE_IR] = 1'b1;
          c.b_select = BSEL_FOUR;
        end
        PH_DECODE: begin
          if (op == OP_RTYPE && fn == FN_HALT) begin
            c.halted = 1'b1;
          end else if (op == OP_J) begin
            nxt = PH_FETCH;
            c.load_enables[LE_PC] = 1'b1;
            c.pc_select = 1'b1;
          end else if (op == OP_ADDI) begin
            nxt = PH_EXEC;
            c.load_enables[LE_ALU] = 1'b1;
            c.a_select = 1'b1;
            c.b_select = BSEL_IMM;
          end else if (arith) begin
            nxt = PH_EXEC;
            c.load_enables[LE_ALU] = 1'b1;
            c.a_select = 1'b1;
            c.b_select = BSEL_REG;
            c.alu_func = (fn == FN_SUB) ? ALU_SUB : ALU_ADD;
          end else if (op == OP_SW) begin
            nxt = PH_EXEC;
            c.load_enables[LE_MAR]   = 1'b1;
            c.load_enables[LE_STORE] = 1'b1;
            c.a_select = 1'b1;
            c.b_select = BSEL_IMM;
          end else if (op == OP_LW) begin
            nxt = PH_EXEC;
            c.load_enables[LE_MAR] = 1'b1;
            c.a_select = 1'b1;
            c.b_select = BSEL_IMM;
          end else if (op == OP_BEQ || op == OP_BNE) begin
            nxt = PH_EXEC;
            c.a_select = 1'b1;
            c.b_select = BSEL_REG;
            c.alu_func = ALU_SUB;
          end else begin
            c.halted = 1'b1;
          end
        end
        PH_EXEC: begin
          if (op == OP_ADDI) begin
            nxt = PH_FETCH;
            c.load_enables[LE_REG] = 1'b1;
            c.write_reg_select = 1'b1;
          end else if (arith) begin
            nxt = PH_FETCH;
            c.load_enables[LE_REG] = 1'b1;
          end else if (op == OP_SW) begin
            nxt = PH_FETCH;
            c.mem_write   = 1'b1;
            c.addr_select = 1'b1;
          end else if (op == OP_LW) begin
            nxt = PH_MEM;
            c.mem_read = 1'b1;
            c.load_enables[LE_LOAD] = 1'b1;
            c.addr_select = 1'b1;
          end else if (op == OP_BEQ || op == OP_BNE) begin
            nxt = PH_FETCH;
            if (taken) begin
              c.load_enables[LE_PC] = 1'b1;
              c.b_select = BSEL_IMM_X4;
            end
          end else begin
            c.halted = 1'b1;
          end
        end
        default: begin
          if (op == OP_LW) begin
            nxt = PH_FETCH;
            c.load_enables[LE_REG] = 1'b1;
            c.write_reg_select = 1'b1;
            c.reg_write_select = 1'b1;
          end else begin
            c.halted = 1'b1;
          end
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] ctrl beat %0d: %s", $time, ctrl_beat_no, what);
    fail_count++;
  endtask

  task automatic cmp_field(input string name, input logic [6:0] got,
                           input logic [6:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    ctrl_t  want;
    ctrl_t  pred;
    phase_t nxt;
    if (rst) begin
      model_phase = PH_FETCH;
      model_halt  = 1'b0;
      ctrl_due_q.delete();
    end else begin
      // drain side first, latency keeps this beat's prediction out of reach
      if (ctrl_mon.valid && ctrl_mon.ready) begin
        if (ctrl_due_q.size() == 0) begin
          report_mismatch("ctrl beat with nothing due");
        end else begin
          want = ctrl_due_q.pop_front();
          cmp_field("halted", 7'(ctrl_mon.halted), 7'(want.halted));
          cmp_field("mem_read", 7'(ctrl_mon.mem_read), 7'(want.mem_read));
          cmp_field("mem_write", 7'(ctrl_mon.mem_write), 7'(want.mem_write));
          cmp_field("load_enables", ctrl_mon.load_enables, want.load_enables);
          cmp_field("write_reg_select", 7'(ctrl_mon.write_reg_select),
                    7'(want.write_reg_select));
          cmp_field("pc_select", 7'(ctrl_mon.pc_select), 7'(want.pc_select));
          cmp_field("addr_select", 7'(ctrl_mon.addr_select), 7'(want.addr_select));
          cmp_field("a_select", 7'(ctrl_mon.a_select), 7'(want.a_select));
          cmp_field("b_select", 7'(ctrl_mon.b_select), 7'(want.b_select));
          cmp_field("reg_write_select", 7'(ctrl_mon.reg_write_select),
                    7'(want.reg_write_select));
          cmp_field("alu_func", 7'(ctrl_mon.alu_func), 7'(want.alu_func));
          cmp_field("phase", 7'(ctrl_mon.phase), 7'(want.phase));
        end
        ctrl_beat_no++;
      end
      if (fetch_mon.valid && fetch_mon.ready) begin
        ctrl_for_beat(model_phase, model_halt, fetch_mon.opcode,
                      fetch_mon.func_field, fetch_mon.zero, pred, nxt);
        ctrl_due_q.push_back(pred);
        if (pred.halted) model_halt = 1'b1;
        else             model_phase = nxt;
      end
    end
    ctrl_due_count <= ctrl_due_q.size();
  end

endmodule

// File: tb/tb_multicycle_mips_control_fsm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multicycle_mips_control_fsm_core
// drives instruction field beats through the control unit and lets the
// checker compare every control beat; halt is sticky, so the run ends on it
// ----------------------------------------------------------------------------
module tb_multicycle_mips_control_fsm_core;
  import mmcf_pkg::*;

  // directed part plus about 800 random beats
  localparam int BEAT_TARGET = 830;
  localparam int CYCLE_LIMIT = 200000;

  // receiver stall styles
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  mmcf_in_if  fetch_bus ();
  mmcf_out_if ctrl_bus ();

  multicycle_mips_control_fsm_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .fetch (fetch_bus),
    .ctrl  (ctrl_bus)
  );

  int fail_count;
  int ctrl_due_count;

  mmcf_ctrl_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .fetch_mon      (fetch_bus),
    .ctrl_mon       (ctrl_bus),
    .fail_count     (fail_count),
    .ctrl_due_count (ctrl_due_count)
  );

  // --------------------------------------------------------------------------
  // receiver: ready follows a pattern of its own, switching style at random
  // times; the open style gives stretches with no stalls at all
  // --------------------------------------------------------------------------
  logic     rx_ready = 1'b0;
  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_left  = 0;

  assign ctrl_bus.ready = rx_ready;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(4, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   rx_ready <= 1'b1;
      RX_COIN:   rx_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: rx_ready <= ($urandom_range(0, 3) == 0);
      default:   rx_ready <= (rx_left[3:0] == 4'd0);   // long stalls
    endcase
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  int beats_sent = 0;
  int burst_left = 0;

  // operation mix for the decode beat and for the execute beat; r-type shows
  // up twice so add and sub get their share
  logic [5:0] decode_ops [8] = '{OP_J, OP_ADDI, OP_RTYPE, OP_RTYPE,
                                 OP_SW, OP_LW, OP_BEQ, OP_BNE};
  logic [5:0] exec_ops   [7] = '{OP_ADDI, OP_RTYPE, OP_RTYPE, OP_SW,
                                 OP_LW, OP_BEQ, OP_BNE};

  // one beat on fetch; returns at the edge where it is taken, then maybe
  // drops valid for a gap when the current burst is used up
  task automatic send_beat(input logic [5:0] op, input logic [5:0] fn,
                           input logic z);
    int gap;
    fetch_bus.valid      <= 1'b1;
    fetch_bus.opcode     <= op;
    fetch_bus.func_field <= fn;
    fetch_bus.zero       <= z;
    do @(posedge clk); while (!fetch_bus.ready);
    beats_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = $urandom_range(1, 6);
      fetch_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // a whole instruction: fetch beat with random fields, decode beat, then the
  // execute beat (skipped for a jump) and the memory beat when it is a load
  task automatic send_instr(input logic [5:0] dec_op, input logic [5:0] dec_fn,
                            input logic [5:0] exe_op, input logic [5:0] exe_fn,
                            input logic z);
    send_beat(6'($urandom), 6'($urandom), 1'($urandom));
    send_beat(dec_op, dec_fn, 1'($urandom));
    if (dec_op != OP_J) begin
      send_beat(exe_op, exe_fn, z);
      if (exe_op == OP_LW) send_beat(OP_LW, 6'($urandom), 1'($urandom));
    end
  endtask

  // an opcode/function pair that execute does not know; at decode it halts
  task automatic junk_instr(output logic [5:0] op, output logic [5:0] fn);
    logic known;
    do begin
      op = 6'($urandom);
      fn = 6'($urandom);
      case (op)
        OP_ADDI, OP_SW, OP_LW, OP_BEQ, OP_BNE, OP_J: known = 1'b1;
        OP_RTYPE: known = (fn == FN_ADD || fn == FN_SUB);
        default:  known = 1'b0;
      endcase
    end while (known);
  endtask

  // --------------------------------------------------------------------------
  // watchdog: a stuck handshake ends the run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [5:0] dop, dfn, eop, efn, bad_op, bad_fn;
    int         pick;

    fetch_bus.valid      = 1'b0;
    fetch_bus.opcode     = '0;
    fetch_bus.func_field = '0;
    fetch_bus.zero       = 1'b0;

    // single reset
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every instruction once, both branch outcomes of beq and bne,
    // function field at both extremes where it is a don't care
    send_instr(OP_RTYPE, FN_ADD, OP_RTYPE, FN_ADD, 1'b0);
    send_instr(OP_RTYPE, FN_SUB, OP_RTYPE, FN_SUB, 1'b1);
    send_instr(OP_ADDI, 6'h3f, OP_ADDI, 6'h3f, 1'b1);
    send_instr(OP_SW, 6'h00, OP_SW, 6'h00, 1'b0);
    send_instr(OP_LW, 6'h3f, OP_LW, 6'h3f, 1'b1);
    send_instr(OP_BEQ, 6'h00, OP_BEQ, 6'h00, 1'b1);   // beq taken
    send_instr(OP_BEQ, 6'h3f, OP_BEQ, 6'h3f, 1'b0);   // beq falls through
    send_instr(OP_BNE, 6'h00, OP_BNE, 6'h00, 1'b0);   // bne taken
    send_instr(OP_BNE, 6'h3f, OP_BNE, 6'h3f, 1'b1);   // bne falls through
    send_instr(OP_J, 6'h3f, OP_J, 6'h3f, 1'b0);

    // random well-formed instructions; a quarter of them draw the execute opcode
    // anew, which may change it between decode and execute; that is legal as long
    // as no phase sees an unknown pair
    while (beats_sent < BEAT_TARGET) begin
      dop = decode_ops[$urandom_range(0, 7)];
      dfn = (dop == OP_RTYPE) ? ($urandom_range(0, 1) ? FN_ADD : FN_SUB)
                              : 6'($urandom);
      eop = ($urandom_range(0, 3) == 0) ? exec_ops[$urandom_range(0, 6)] : dop;
      if (eop == OP_RTYPE) efn = $urandom_range(0, 1) ? FN_ADD : FN_SUB;
      else if (eop == dop) efn = dfn;
      else                 efn = 6'($urandom);
      send_instr(dop, dfn, eop, efn, 1'($urandom));
    end

    // halt is sticky until reset, so exactly one way into it ends the run
    pick = $urandom_range(0, 3);
    send_beat(6'($urandom), 6'($urandom), 1'($urandom));
    case (pick)
      0: begin
        // halt instruction at decode
        send_beat(OP_RTYPE, FN_HALT, 1'($urandom));
      end
      1: begin
        // unknown instruction at decode
        junk_instr(bad_op, bad_fn);
        send_beat(bad_op, bad_fn, 1'($urandom));
      end
      2: begin
        // known at decode, unknown at execute
        send_beat(OP_ADDI, 6'($urandom), 1'($urandom));
        junk_instr(bad_op, bad_fn);
        send_beat(bad_op, bad_fn, 1'($urandom));
      end
      default: begin
        // load gets to the memory phase, then something other than lw
        send_beat(OP_LW, 6'($urandom), 1'($urandom));
        send_beat(OP_LW, 6'($urandom), 1'($urandom));
        do bad_op = 6'($urandom); while (bad_op == OP_LW);
        send_beat(bad_op, 6'($urandom), 1'($urandom));
      end
    endcase

    // once halted everything is ignored; a few beats confirm it stays stuck
    repeat (12) send_beat(6'($urandom), 6'($urandom), 1'($urandom));
    fetch_bus.valid <= 1'b0;

    // drain, then let the two pipeline stages settle
    do @(posedge clk); while (ctrl_due_count != 0);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && ctrl_due_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
